[rtl/local_boundary_strength_unit_assert.svh]
// ----------------------------------------------------------------------------
// local_boundary_strength_unit_assert.svh
// Assertion macros shared by the boundary strength unit.
// ----------------------------------------------------------------------------
`ifndef LOCAL_BOUNDARY_STRENGTH_UNIT_ASSERT_SVH
`define LOCAL_BOUNDARY_STRENGTH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define LBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lbs assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define LBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lbs assertion failed");

`endif

[rtl/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// Widths and control/status types for the boundary strength unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int VALUE_W     = 16;             // Q8.8 profile value
    localparam int CHANGE_W    = 24;             // Q8.16 change
    localparam int CSUM_W      = CHANGE_W + 1;   // sum of two changes
    localparam int STRENGTH_W  = 25;             // Q17.8 strength
    localparam int OPND_W      = VALUE_W + 1;    // divider sum / diff width
    localparam int QUOT_W      = VALUE_W + 1;    // ratio can reach 1.0
    localparam int DIV_STEPS   = QUOT_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int FRAC_SHIFT  = 16;
    localparam int PROD_W      = VALUE_W + CSUM_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic load_in;
        logic div_first;
        logic div_step;
        logic sum_load;
        logic mul_load;
        logic mul_final;
        logic out_load;
        logic out_last;
        logic commit;
    } lbs_cmd_t;

    typedef struct packed {
        logic has_prior;
        logic last_flag;
        logic out_free;
    } lbs_status_t;

endpackage

[rtl/lbs_ctrl.sv]
// ----------------------------------------------------------------------------
// lbs_ctrl
// Sequencer: input accept, divider steps, multiply and emit, state commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  lbs_pkg::lbs_status_t status,
    output lbs_pkg::lbs_cmd_t    cmd
);
    import lbs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIV    = 7'b0000010,
        ST_SUM    = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_EMIT   = 7'b0010000,
        ST_FINAL  = 7'b0100000,
        ST_COMMIT = 7'b1000000
    } lbs_state_t;

    lbs_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // ST_FINAL is used twice: multiply, then emit once the output register is free
    logic fin_emit_reg, fin_emit_next;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fin_emit_next = fin_emit_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cnt_next      = '0;
                fin_emit_next = 1'b0;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (status.has_prior) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_FINAL;
                    end else begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.last_flag ? ST_FINAL : ST_COMMIT;
                end
            end
            ST_FINAL: begin
                if (!fin_emit_reg) begin
                    cmd.mul_load  = 1'b1;
                    cmd.mul_final = 1'b1;
                    fin_emit_next = 1'b1;
                end else if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = 1'b1;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            fin_emit_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fin_emit_reg <= fin_emit_next;
        end
    end

endmodule

[rtl/lbs_datapath.sv]
// ----------------------------------------------------------------------------
// lbs_datapath
// Sequence state, radix-2 ratio divider, strength multiplier, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [lbs_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] profile_value
    input  logic                                s_tlast,   // last_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lbs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [24:0] strength
    output logic                                m_tlast,   // last_out
    input  lbs_pkg::lbs_cmd_t                   cmd,
    output lbs_pkg::lbs_status_t                status
);
    import lbs_pkg::*;

    // sequence state
    logic [VALUE_W-1:0]  prior_value_reg;
    logic [CHANGE_W-1:0] prior_change_reg;
    logic                has_prior_reg;

    // current word
    logic [VALUE_W-1:0]  v_reg;
    logic                last_reg;
    logic [CHANGE_W-1:0] change_reg;
    logic [CSUM_W-1:0]   csum_reg;

    // divider
    logic [OPND_W-1:0]   diff_reg;
    logic [OPND_W-1:0]   sum_reg;
    logic [OPND_W-1:0]   rem_reg;
    logic [QUOT_W-1:0]   quot_reg;

    logic [PROD_W-1:0]   prod_reg;

    logic                    out_valid_reg;
    logic [STRENGTH_W-1:0]   out_strength_reg;
    logic                    out_last_reg;

    logic [OPND_W-1:0]   in_sum;
    logic [OPND_W-1:0]   in_diff;
    logic [OPND_W:0]     trial;
    logic                trial_ge;
    logic [OPND_W-1:0]   rem_next;
    logic [CHANGE_W-1:0] change_fin;
    logic [VALUE_W-1:0]  mul_a;
    logic [CSUM_W-1:0]   mul_b;

    assign in_sum  = {1'b0, prior_value_reg} + {1'b0, s_tdata[VALUE_W-1:0]};
    assign in_diff = (prior_value_reg >= s_tdata[VALUE_W-1:0])
                   ? {1'b0, prior_value_reg - s_tdata[VALUE_W-1:0]}
                   : {1'b0, s_tdata[VALUE_W-1:0] - prior_value_reg};

    // first step tests diff itself (ratio 1.0 when one side is zero),
    // later steps shift a zero into the remainder
    assign trial    = cmd.div_first ? {1'b0, diff_reg} : {rem_reg, 1'b0};
    assign trial_ge = (trial >= {1'b0, sum_reg});
    assign rem_next = trial_ge ? OPND_W'(trial - {1'b0, sum_reg}) : OPND_W'(trial);

    assign change_fin = (sum_reg == '0) ? '0 : CHANGE_W'(quot_reg);

    assign mul_a = cmd.mul_final ? v_reg : prior_value_reg;
    assign mul_b = cmd.mul_final ? {1'b0, change_reg} : csum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            v_reg      <= s_tdata[VALUE_W-1:0];
            last_reg   <= s_tlast;
            change_reg <= {s_tdata[VALUE_W-1:0], 8'h00};
            diff_reg   <= in_diff;
            sum_reg    <= in_sum;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
        end
        if (cmd.sum_load) begin
            change_reg <= change_fin;
            csum_reg   <= {1'b0, prior_change_reg} + {1'b0, change_fin};
        end
        if (cmd.mul_load) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.commit) begin
            prior_value_reg  <= v_reg;
            prior_change_reg <= change_reg;
        end
        if (cmd.out_load) begin
            out_strength_reg <= prod_reg[FRAC_SHIFT +: STRENGTH_W];
            out_last_reg     <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_prior_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                has_prior_reg <= !last_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.has_prior = has_prior_reg;
    assign status.last_flag = last_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_strength_reg);
    assign m_tlast  = out_last_reg;

endmodule

[rtl/local_boundary_strength_unit.sv]
// An accepted word yields its neighbor's strength word after the divider, sum,
// multiply and emit states; a word closing a sequence then emits its own too, and a
// sequence's first word skips them. No new word is taken until the last is committed;
// the 17-step radix-2 ratio divider paces it. Output register frees the input side.
// Reset (aresetn low, synchronous) drops any word in progress, clears the
// output valid and starts a new sequence.
// ----------------------------------------------------------------------------
// local_boundary_strength_unit
// Streaming boundary strength from Q8.8 profile values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_boundary_strength_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lbs_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] profile_value
    input  logic                                s_tlast,   // last_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lbs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [24:0] strength, rest zero
    output logic                                m_tlast    // last_out
);
    import lbs_pkg::*;

    lbs_cmd_t    cmd;
    lbs_status_t status;

    lbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lbs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

`include "local_boundary_strength_unit_assert.svh"

    // a sequence's first word, not last, is stored and ready returns quickly
    `LBS_ASSERT_NOW(a_first_word_quick, s_tvalid && s_tready && !status.has_prior && !s_tlast, ##2 s_tready)
    // once a word is taken the block is busy on the next cycle
    `LBS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // sequence flag only moves at commit
    `LBS_ASSERT_NEXT(a_prior_only_at_commit, !cmd.commit, $stable(status.has_prior))

endmodule
